// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the wildcard matcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Request codes, character constants, cell control types and case folding.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int CHAR_W           = 16;

    localparam logic [CHAR_W-1:0] CH_STAR     = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 16'h003F;
    localparam logic [CHAR_W-1:0] CH_UPPER_A  = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 16'h005A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 16'h0061;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_END    = 2'd3
    } t_req;

    // Broadcast to every cell for one accepted item.
    typedef struct packed {
        logic              clear;
        logic              append;
        logic              text;
        logic              restart;
        logic              star;
        logic              qmark;
        logic [CHAR_W-1:0] code;
    } t_ctrl;

    // Handed from one cell to its right-hand neighbor.
    typedef struct packed {
        logic valid;
        logic carry;
        logic enter;
        logic hit;
    } t_link;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c - CH_UPPER_A + CH_LOWER_A;
        end
        return r;
    endfunction

endpackage

// ----- rtl/wildcard_glob_matcher.sv -----
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Matches streamed text against a stored pattern with '*' and '?' wildcards.
// ----------------------------------------------------------------------------
//  Channel  Valid / ready             Payload
//  input    i_in_valid / o_in_ready   i_req_type, i_char_code
//  output   o_out_valid / i_out_ready o_matched, o_pattern_overflow
//
//  A new item can be accepted in every cycle, save for the end-of-text wait below.
//  The critical path is the star carry chain through the row of cells.
//  Reset leaves an empty pattern with only position zero active.
//  An end-of-text item waits while a result is held and not taken; other
//  items are accepted regardless of the output side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_glob_matcher #(
    parameter int PATTERN_CAPACITY = wgm_pkg::DEFAULT_CAPACITY
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [wgm_pkg::CHAR_W-1:0] i_char_code,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_matched,
    output logic                       o_pattern_overflow
);

    localparam int CAP = PATTERN_CAPACITY;

    wgm_pkg::t_ctrl                    w_ctrl;
    wgm_pkg::t_link                    w_prev [CAP];
    wgm_pkg::t_link                    w_link [CAP];
    logic                              w_fire;
    logic                              w_nonzero;
    logic                              w_full;
    logic                              w_tail_closed;
    logic                              w_tail_hit;
    logic                              w_matched;
    logic [CAP-1:0]                    w_hit;
    logic [CAP-1:0]                    w_valid_vec;
    logic [CAP-1:0]                    w_active_vec;
    logic [CAP-1:0]                    w_valid_inc;
    logic [CAP-1:0]                    w_reach;
    logic                              r_tail_active;
    logic                              n_tail_active;
    logic                              r_overflow;
    logic                              n_overflow;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic                              r_matched;
    logic                              r_out_overflow;

    assign o_in_ready = !r_out_valid || i_out_ready
                        || (wgm_pkg::t_req'(i_req_type) != wgm_pkg::REQ_END);
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_nonzero  = (i_char_code != '0);

    always_comb begin
        w_ctrl         = '0;
        w_ctrl.code    = wgm_pkg::fold_case(i_char_code);
        w_ctrl.star    = (i_char_code == wgm_pkg::CH_STAR);
        w_ctrl.qmark   = (i_char_code == wgm_pkg::CH_QUESTION);
        if (w_fire) begin
            unique case (wgm_pkg::t_req'(i_req_type))
                wgm_pkg::REQ_CLEAR:  w_ctrl.clear   = 1'b1;
                wgm_pkg::REQ_APPEND: w_ctrl.append  = w_nonzero;
                wgm_pkg::REQ_TEXT:   w_ctrl.text    = w_nonzero;
                wgm_pkg::REQ_END:    w_ctrl.restart = 1'b1;
                default:             w_ctrl.clear   = 1'b0;
            endcase
        end
    end

    generate
        for (genvar g = 0; g < CAP; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g] = '{valid: 1'b1, carry: 1'b0, enter: 1'b0, hit: 1'b0};
            end else begin : g_body
                assign w_prev[g] = w_link[g-1];
            end

            wgm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_head  (g == 0),
                .i_ctrl  (w_ctrl),
                .i_prev  (w_prev[g]),
                .o_link  (w_link[g])
            );

            assign w_hit[g]        = w_link[g].hit;
            assign w_valid_vec[g]  = w_link[g].valid;
            assign w_active_vec[g] = u_cell.r_active;
        end
    endgenerate

    assign w_full        = w_link[CAP-1].valid;
    assign w_tail_closed = r_tail_active | w_link[CAP-1].carry;
    assign w_tail_hit    = w_tail_closed & w_full;
    assign w_matched     = (|w_hit) | w_tail_hit;

    always_comb begin
        n_tail_active = r_tail_active;
        n_overflow    = r_overflow;
        if (w_ctrl.clear) begin
            n_tail_active = 1'b0;
            n_overflow    = 1'b0;
        end else if (w_ctrl.restart) begin
            n_tail_active = 1'b0;
        end else if (w_ctrl.text) begin
            n_tail_active = w_link[CAP-1].enter;
        end else if (w_ctrl.append && w_full) begin
            n_overflow = 1'b1;
        end
        n_out_valid = w_ctrl.restart || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_active <= 1'b0;
            r_overflow    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_tail_active <= n_tail_active;
            r_overflow    <= n_overflow;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.restart) begin
            r_matched      <= w_matched;
            r_out_overflow <= r_overflow;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_out_overflow;

    assign w_valid_inc = w_valid_vec + CAP'(1);
    assign w_reach     = (w_valid_vec << 1) | CAP'(1);

    // The stored pattern always fills the cells from the left without gaps.
    `ASSERT_SAME(a_valid_packed, i_clk, i_rst_n, 1'b1, (w_valid_vec & w_valid_inc) == '0)
    // No position beyond the current pattern length is ever active.
    `ASSERT_SAME(a_active_in_range, i_clk, i_rst_n, 1'b1,
        ((w_active_vec & ~w_reach) == '0) && (!r_tail_active || w_full))
    // A clear leaves only position zero active and no overflow.
    `ASSERT_NEXT(a_clear_restarts, i_clk, i_rst_n, w_ctrl.clear,
        (w_active_vec == CAP'(1)) && !r_tail_active && !r_overflow)

endmodule

// ----- rtl/wgm_cell.sv -----
// ----------------------------------------------------------------------------
// Wildcard matcher cell
// Holds one pattern character and the active flag of its pattern position.
// ----------------------------------------------------------------------------
module wgm_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head,
    input  wgm_pkg::t_ctrl i_ctrl,
    input  wgm_pkg::t_link i_prev,
    output wgm_pkg::t_link o_link
);

    logic                       r_valid;
    logic                       r_active;
    logic                       r_star;
    logic                       r_qmark;
    logic [wgm_pkg::CHAR_W-1:0] r_char;
    logic                       n_valid;
    logic                       n_active;
    logic                       w_closed;
    logic                       w_write;

    assign w_closed = r_active | i_prev.carry;
    assign w_write  = i_ctrl.append && i_prev.valid && !r_valid;

    assign o_link.valid = r_valid;
    assign o_link.carry = w_closed & r_valid & r_star;
    assign o_link.enter = w_closed & r_valid & !r_star
                          & (r_qmark | (r_char == i_ctrl.code));
    assign o_link.hit   = w_closed & i_prev.valid & !r_valid;

    always_comb begin
        n_valid  = r_valid;
        n_active = r_active;
        if (i_ctrl.clear) begin
            n_valid  = 1'b0;
            n_active = i_head;
        end else if (i_ctrl.restart) begin
            n_active = i_head;
        end else if (i_ctrl.text) begin
            n_active = (w_closed & r_valid & r_star) | i_prev.enter;
        end else if (w_write) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_active <= i_head;
        end else begin
            r_valid  <= n_valid;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_char  <= i_ctrl.code;
            r_star  <= i_ctrl.star;
            r_qmark <= i_ctrl.qmark;
        end
    end

endmodule
